// File: sv/thbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thbc_pkg
// Shared types and constants for the tap/hold button controller.
// ----------------------------------------------------------------------------
package thbc_pkg;

  // Input word: one tick.
  typedef struct packed {
    logic [31:0] now_ms;
    logic        pressed;
  } in_word_t;

  // Result word: one per tick.
  typedef struct packed {
    logic [7:0] brightness_out;
    logic [3:0] program_out;
    logic       program_changed;
    logic       save_now;
  } out_word_t;

  // Configuration register set.
  typedef struct packed {
    logic [7:0]  bright_floor;
    logic [7:0]  bright_ceil;
    logic [15:0] hold_ms;
    logic [15:0] repeat_ms;
    logic [15:0] tap_min_ms;
    logic [15:0] tap_max_ms;
    logic [31:0] save_delay_ms;
  } cfg_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT_FLOOR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT_CEIL    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_MS        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_MS      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_MIN_MS     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_MAX_MS     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SAVE_DELAY_MS  = 3'd6;

  // Reset values.
  localparam logic [7:0]  RST_BRIGHT_FLOOR   = 8'd1;
  localparam logic [7:0]  RST_BRIGHT_CEIL    = 8'd50;
  localparam logic [15:0] RST_HOLD_MS        = 16'd1000;
  localparam logic [15:0] RST_REPEAT_MS      = 16'd200;
  localparam logic [15:0] RST_TAP_MIN_MS     = 16'd10;
  localparam logic [15:0] RST_TAP_MAX_MS     = 16'd300;
  localparam logic [31:0] RST_SAVE_DELAY_MS  = 32'd10000;

endpackage

// File: sv/thbc_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thbc_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module thbc_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [thbc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [thbc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output thbc_pkg::cfg_t                   cfg_o
);

  thbc_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bright_floor   <= thbc_pkg::RST_BRIGHT_FLOOR;
      cfg_r.bright_ceil    <= thbc_pkg::RST_BRIGHT_CEIL;
      cfg_r.hold_ms        <= thbc_pkg::RST_HOLD_MS;
      cfg_r.repeat_ms      <= thbc_pkg::RST_REPEAT_MS;
      cfg_r.tap_min_ms     <= thbc_pkg::RST_TAP_MIN_MS;
      cfg_r.tap_max_ms     <= thbc_pkg::RST_TAP_MAX_MS;
      cfg_r.save_delay_ms  <= thbc_pkg::RST_SAVE_DELAY_MS;
    end else if (cfg_we) begin
      case (cfg_index)
        thbc_pkg::CFG_BRIGHT_FLOOR:   cfg_r.bright_floor   <= cfg_wdata[7:0];
        thbc_pkg::CFG_BRIGHT_CEIL:    cfg_r.bright_ceil    <= cfg_wdata[7:0];
        thbc_pkg::CFG_HOLD_MS:        cfg_r.hold_ms        <= cfg_wdata[15:0];
        thbc_pkg::CFG_REPEAT_MS:      cfg_r.repeat_ms      <= cfg_wdata[15:0];
        thbc_pkg::CFG_TAP_MIN_MS:     cfg_r.tap_min_ms     <= cfg_wdata[15:0];
        thbc_pkg::CFG_TAP_MAX_MS:     cfg_r.tap_max_ms     <= cfg_wdata[15:0];
        thbc_pkg::CFG_SAVE_DELAY_MS:  cfg_r.save_delay_ms  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_r;

endmodule

// File: sv/thbc_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thbc_core
// Button decode state and the per-tick update: hold stepping, tap detect,
// save timing.
// ----------------------------------------------------------------------------
module thbc_core #(
  parameter int NUM_PROGRAMS = 13
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fire,
  input  thbc_pkg::in_word_t    item,
  input  thbc_pkg::cfg_t        cfg,
  output thbc_pkg::out_word_t   result
);

  localparam logic [4:0] NUM_PROG_W = 5'(NUM_PROGRAMS);

  logic        was_pressed_r, was_pressed_nxt;
  logic [31:0] press_time_r, press_time_nxt;
  logic [7:0]  bright_r, bright_nxt;
  logic [3:0]  prog_r, prog_nxt;
  logic        saved_r, saved_nxt, saved_fin;
  logic [31:0] last_chg_r, last_chg_nxt;

  logic [31:0] press_base;
  logic [31:0] held;
  logic [4:0]  prog_inc;
  logic        prog_chg;
  logic        save;

  always_comb begin
    was_pressed_nxt = was_pressed_r;
    press_time_nxt  = press_time_r;
    bright_nxt      = bright_r;
    prog_nxt        = prog_r;
    saved_nxt       = saved_r;
    last_chg_nxt    = last_chg_r;
    prog_chg        = 1'b0;
    prog_inc        = {1'b0, prog_r} + 5'd1;

    // Latch the press time on the press edge.
    press_base = (item.pressed && !was_pressed_r) ? item.now_ms : press_time_r;
    held       = item.now_ms - press_base;

    if (item.pressed) begin
      was_pressed_nxt = 1'b1;
      press_time_nxt  = press_base;
      if (held > {16'd0, cfg.hold_ms}) begin
        // Step down, wrap to the ceiling at or below the floor.
        bright_nxt     = (bright_r <= cfg.bright_floor) ? cfg.bright_ceil
                                                        : bright_r - 8'd1;
        press_time_nxt = press_base + {16'd0, cfg.repeat_ms};
        last_chg_nxt   = item.now_ms;
        saved_nxt      = 1'b0;
      end
    end else begin
      was_pressed_nxt = 1'b0;
      if (was_pressed_r && held > {16'd0, cfg.tap_min_ms}
          && held < {16'd0, cfg.tap_max_ms}) begin
        prog_nxt     = (prog_inc >= NUM_PROG_W) ? 4'd0 : prog_inc[3:0];
        prog_chg     = 1'b1;
        last_chg_nxt = item.now_ms;
        saved_nxt    = 1'b0;
      end
    end

    // Save check sees the updated change time.
    save      = ((item.now_ms - last_chg_nxt) > cfg.save_delay_ms) && !saved_nxt;
    saved_fin = saved_nxt | save;

    result.brightness_out  = bright_nxt;
    result.program_out     = prog_nxt;
    result.program_changed = prog_chg;
    result.save_now        = save;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      was_pressed_r <= 1'b0;
      press_time_r  <= 32'd0;
      bright_r      <= thbc_pkg::RST_BRIGHT_CEIL;
      prog_r        <= 4'd0;
      saved_r       <= 1'b1;
      last_chg_r    <= 32'd0;
    end else if (fire) begin
      was_pressed_r <= was_pressed_nxt;
      press_time_r  <= press_time_nxt;
      bright_r      <= bright_nxt;
      prog_r        <= prog_nxt;
      saved_r       <= saved_fin;
      last_chg_r    <= last_chg_nxt;
    end
  end

endmodule

// File: sv/tap_hold_button_controller.sv
`timescale 1ns / 1ps
// Path: the word passes the input register, then the result register, and a
// result-channel stall can hold it between them. Throughput: one word per
// cycle while out_stall is low; the decode core updates its state per transfer.
// Reset (rst_n low, synchronous): all but the payload registers return to
// their reset values: brightness 50, program 0, both pipeline stages empty.
// ----------------------------------------------------------------------------
// tap_hold_button_controller
// Decodes a timestamped button level into brightness stepping while held,
// program advance on a tap, and a delayed save request after changes.
// ----------------------------------------------------------------------------
module tap_hold_button_controller #(
  parameter int NUM_PROGRAMS = 13
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  thbc_pkg::in_word_t               in_data,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output thbc_pkg::out_word_t              out_data,
  // configuration write port
  input  logic                             cfg_we,
  input  logic [thbc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [thbc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  thbc_pkg::cfg_t      cfg;
  thbc_pkg::out_word_t result;

  // Input register stage.
  logic                s1_valid_r, s1_valid_nxt;
  thbc_pkg::in_word_t  s1_data_r;
  // Result register stage.
  logic                out_valid_r, out_valid_nxt;
  thbc_pkg::out_word_t out_data_r;

  logic in_acc;
  logic s1_fire;

  thbc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  thbc_core #(
    .NUM_PROGRAMS (NUM_PROGRAMS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (s1_fire),
    .item   (s1_data_r),
    .cfg    (cfg),
    .result (result)
  );

  // Advance the held word whenever the result register is free or draining.
  assign s1_fire = s1_valid_r && (!out_valid_r || !out_stall);
  // Hold off new words only while the input stage is full and cannot move.
  assign in_stall = s1_valid_r && !s1_fire;
  assign in_acc   = in_valid && !in_stall;

  assign s1_valid_nxt  = in_acc || (s1_valid_r && !s1_fire);
  assign out_valid_nxt = s1_fire || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: capture on transfer, hold otherwise.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_data_r <= in_data;
    end
    if (s1_fire) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: bench/tb_tap_hold_button_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tap_hold_button_controller
// Drives timestamped button ticks into the controller, predicts each result
// word in a scoreboard that tracks press timing, brightness, program and save
// state, and compares every accepted result word field by field. Runs a
// directed opening, then random tap/hold/quiet gestures over several register
// settings, with random idling on both channels in most phases.
// ----------------------------------------------------------------------------
module tb_tap_hold_button_controller;

  localparam int PROGRAM_COUNT = 13;
  localparam int SETTLE_CYCLES = 8;       // margin beyond the two pipeline stages
  localparam int CYCLE_LIMIT   = 500000;
  localparam int PHASE_COUNT   = 10;
  localparam int PHASE_WORDS   = 113;

  // Scoreboard: private copy of the controller state and registers, plus the
  // queue of result words still owed by the block.
  class tick_scoreboard;
    thbc_pkg::cfg_t      regs;
    logic                was_down;
    logic [31:0]         press_ms;
    logic [7:0]          level;
    logic [3:0]          prog;
    logic                saved;
    logic [31:0]         change_ms;
    thbc_pkg::out_word_t owed_q[$];
    int                  errors;

    function new();
      regs.bright_floor   = thbc_pkg::RST_BRIGHT_FLOOR;
      regs.bright_ceil    = thbc_pkg::RST_BRIGHT_CEIL;
      regs.hold_ms        = thbc_pkg::RST_HOLD_MS;
      regs.repeat_ms      = thbc_pkg::RST_REPEAT_MS;
      regs.tap_min_ms     = thbc_pkg::RST_TAP_MIN_MS;
      regs.tap_max_ms     = thbc_pkg::RST_TAP_MAX_MS;
      regs.save_delay_ms  = thbc_pkg::RST_SAVE_DELAY_MS;
      was_down  = 1'b0;
      press_ms  = '0;
      level     = thbc_pkg::RST_BRIGHT_CEIL;
      prog      = '0;
      saved     = 1'b1;
      change_ms = '0;
      errors    = 0;
    endfunction

    function void set_register(logic [thbc_pkg::CFG_IDX_W-1:0] idx,
                               logic [thbc_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        thbc_pkg::CFG_BRIGHT_FLOOR:  regs.bright_floor   = val[7:0];
        thbc_pkg::CFG_BRIGHT_CEIL:   regs.bright_ceil    = val[7:0];
        thbc_pkg::CFG_HOLD_MS:       regs.hold_ms        = val[15:0];
        thbc_pkg::CFG_REPEAT_MS:     regs.repeat_ms      = val[15:0];
        thbc_pkg::CFG_TAP_MIN_MS:    regs.tap_min_ms     = val[15:0];
        thbc_pkg::CFG_TAP_MAX_MS:    regs.tap_max_ms     = val[15:0];
        thbc_pkg::CFG_SAVE_DELAY_MS: regs.save_delay_ms  = val;
        default: ;
      endcase
    endfunction

    // Advance the decoder by one tick and return the result word it yields.
    function thbc_pkg::out_word_t decode_tick(thbc_pkg::in_word_t w);
      thbc_pkg::out_word_t r;
      logic [31:0]         held;
      int                  nxt;
      r = '0;
      if (w.pressed) begin
        if (!was_down) begin
          press_ms = w.now_ms;
          was_down = 1'b1;
        end
        held = w.now_ms - press_ms;
        if (held > regs.hold_ms) begin
          // at or below the floor: jump back to the ceiling
          if (level <= regs.bright_floor) level = regs.bright_ceil;
          else level = level - 8'd1;
          press_ms  = press_ms + regs.repeat_ms;
          change_ms = w.now_ms;
          saved     = 1'b0;
        end
      end else begin
        held = w.now_ms - press_ms;
        if (was_down && held > regs.tap_min_ms && held < regs.tap_max_ms) begin
          nxt = prog + 1;
          if (nxt >= PROGRAM_COUNT) nxt = 0;
          prog              = 4'(nxt);
          r.program_changed = 1'b1;
          change_ms         = w.now_ms;
          saved             = 1'b0;
        end
        was_down = 1'b0;
      end
      // save check sees the state after this tick's update
      if ((w.now_ms - change_ms) > regs.save_delay_ms && !saved) begin
        saved      = 1'b1;
        r.save_now = 1'b1;
      end
      r.brightness_out = level;
      r.program_out    = prog;
      return r;
    endfunction

    function void note_tick(thbc_pkg::in_word_t w);
      owed_q.push_back(decode_tick(w));
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    function void cmp_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(thbc_pkg::out_word_t got);
      thbc_pkg::out_word_t want;
      if (owed_q.size() == 0) begin
        $display("%0t: unexpected result word: expected none, actual %h", $time, got);
        errors++;
      end else begin
        want = owed_q.pop_front();
        cmp_field("brightness_out", want.brightness_out, got.brightness_out);
        cmp_field("program_out", 8'(want.program_out), 8'(got.program_out));
        cmp_field("program_changed", 8'(want.program_changed), 8'(got.program_changed));
        cmp_field("save_now", 8'(want.save_now), 8'(got.save_now));
      end
    endfunction
  endclass

  logic                            clk       = 1'b0;
  logic                            rst_n     = 1'b0;
  logic                            in_valid  = 1'b0;
  logic                            in_stall;
  thbc_pkg::in_word_t              in_data   = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  thbc_pkg::out_word_t             out_data;
  logic                            cfg_we    = 1'b0;
  logic [thbc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [thbc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  tick_scoreboard sb;
  logic [31:0]    clock_ms;     // timestamp of the last word sent
  int             words_sent;
  bit             gaps_on;      // sender idles in bursts
  bit             stalls_on;    // receiver stalls in bursts
  int             stall_left    = 0;
  int             cycle_count   = 0;

  always #2 clk = ~clk;

  tap_hold_button_controller #(.NUM_PROGRAMS(PROGRAM_COUNT)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Receiver: stall in random bursts while enabled.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (stalls_on && $urandom_range(0, 7) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 10);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Check every result word taken at this edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // Watchdog: give up well past the slowest correct run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d result words outstanding",
               cycle_count, sb.pending());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Offer one tick word and hold it until the block takes it; note it on accept.
  task automatic send_tick(input logic [31:0] ms, input logic down);
    thbc_pkg::in_word_t w;
    w.now_ms  = ms;
    w.pressed = down;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_tick(w);
    words_sent++;
    clock_ms = ms;
  endtask

  // Drop valid and wait until every owed result word has been checked.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all registers back to back while the block is idle.
  task automatic apply_settings(input thbc_pkg::cfg_t c);
    logic [thbc_pkg::CFG_DATA_W-1:0] vals [7];
    vals[thbc_pkg::CFG_BRIGHT_FLOOR]  = thbc_pkg::CFG_DATA_W'(c.bright_floor);
    vals[thbc_pkg::CFG_BRIGHT_CEIL]   = thbc_pkg::CFG_DATA_W'(c.bright_ceil);
    vals[thbc_pkg::CFG_HOLD_MS]       = thbc_pkg::CFG_DATA_W'(c.hold_ms);
    vals[thbc_pkg::CFG_REPEAT_MS]     = thbc_pkg::CFG_DATA_W'(c.repeat_ms);
    vals[thbc_pkg::CFG_TAP_MIN_MS]    = thbc_pkg::CFG_DATA_W'(c.tap_min_ms);
    vals[thbc_pkg::CFG_TAP_MAX_MS]    = thbc_pkg::CFG_DATA_W'(c.tap_max_ms);
    vals[thbc_pkg::CFG_SAVE_DELAY_MS] = c.save_delay_ms;
    wait_drained();
    for (int i = 0; i < 7; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= thbc_pkg::CFG_IDX_W'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
      sb.set_register(thbc_pkg::CFG_IDX_W'(i), vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic thbc_pkg::cfg_t settings_for(int p);
    thbc_pkg::cfg_t c;
    case (p)
      0: c = '0;                                   // everything at zero
      1: c = '1;                                   // everything at its top
      2: c = '{8'd200, 8'd10, 16'd20, 16'd5, 16'd3, 16'd30, 32'd100};  // floor above ceiling
      3: c = '{8'd45, 8'd50, 16'd15, 16'd0, 16'd2, 16'd25, 32'd60};    // zero repeat interval
      4: c = '{8'd0, 8'd255, 16'd5, 16'd3, 16'd1, 16'd40, 32'd150};
      default: begin
        c.bright_ceil    = 8'($urandom_range(0, 255));
        c.bright_floor   = c.bright_ceil - 8'($urandom_range(0, 6));
        c.hold_ms        = 16'($urandom_range(0, 60));
        c.repeat_ms      = 16'($urandom_range(0, 30));
        c.tap_min_ms     = 16'($urandom_range(0, 20));
        c.tap_max_ms     = 16'($urandom_range(0, 80));
        c.save_delay_ms  = $urandom_range(0, 300);
        if ($urandom_range(0, 3) == 0) begin
          c = {$urandom, $urandom, 16'($urandom), 32'($urandom_range(0, 255))};
        end
      end
    endcase
    return c;
  endfunction

  // One gesture: mostly well-formed taps and holds, some quiet spells and noise.
  task automatic run_gesture();
    int          kind;
    int          d;
    int          stepping;
    logic [31:0] t0;
    kind = $urandom_range(0, 9);
    t0   = clock_ms + $urandom_range(1, 40);
    if (kind < 4) begin
      // tap: length straddles both window edges
      d = $urandom_range(sb.regs.tap_min_ms > 0 ? sb.regs.tap_min_ms - 1 : 0,
                         sb.regs.tap_max_ms + 1);
      send_tick(t0, 1'b1);
      if ($urandom_range(0, 1)) send_tick(t0 + d / 2, 1'b1);
      send_tick(t0 + d, 1'b0);
    end else if (kind < 7) begin
      // hold: land on the hold edge, then ride the repeat interval
      send_tick(t0, 1'b1);
      send_tick(t0 + sb.regs.hold_ms + $urandom_range(0, 2), 1'b1);
      repeat ($urandom_range(1, 12)) begin
        stepping = (sb.regs.repeat_ms == 0) ? $urandom_range(0, 1)
                                            : sb.regs.repeat_ms + $urandom_range(0, 2) - 1;
        send_tick(clock_ms + stepping, 1'b1);
      end
      send_tick(clock_ms + $urandom_range(0, 50), 1'b0);
    end else if (kind < 8) begin
      // quiet spell right at the save delay
      send_tick(clock_ms + sb.regs.save_delay_ms + $urandom_range(0, 2), 1'b0);
    end else begin
      send_tick($urandom, 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    int target;
    sb         = new();
    clock_ms   = '0;
    words_sent = 0;
    gaps_on    = 1'b1;
    stalls_on  = 1'b1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed ticks at the reset settings.
    send_tick(32'd100, 1'b0);
    send_tick(32'd1000, 1'b1);  send_tick(32'd1005, 1'b0);   // too short for a tap
    send_tick(32'd2000, 1'b1);  send_tick(32'd2010, 1'b0);   // exactly the tap minimum
    send_tick(32'd3000, 1'b1);  send_tick(32'd3011, 1'b0);   // tap
    send_tick(32'd4000, 1'b1);  send_tick(32'd4299, 1'b0);   // tap
    send_tick(32'd5000, 1'b1);  send_tick(32'd5300, 1'b0);   // exactly the tap maximum
    send_tick(32'd6000, 1'b1);
    send_tick(32'd7000, 1'b1);                               // exactly the hold time
    send_tick(32'd7001, 1'b1);                               // first step
    send_tick(32'd7201, 1'b1);                               // repeat step
    send_tick(32'd7300, 1'b0);
    send_tick(32'd17301, 1'b0);                              // save after quiet
    send_tick(32'hFFFF_FF80, 1'b1);                          // tap across timestamp wrap
    send_tick(32'h0000_0020, 1'b0);
    send_tick(32'hFFFF_FFFF, 1'b1);
    send_tick(32'h0000_0000, 1'b0);

    // Random phases, one register setting each.
    for (int p = 0; p < PHASE_COUNT; p++) begin
      apply_settings(settings_for(p));
      gaps_on   = (p % 3 != 1) && (p != PHASE_COUNT - 1);
      stalls_on = gaps_on;
      if (p % 3 == 2) clock_ms = 32'hFFFF_FC00 + $urandom_range(0, 255);
      target = words_sent + PHASE_WORDS;
      while (words_sent < target) begin
        run_gesture();
        // hold off now and then until the pipe is empty, only while idling is on
        if (gaps_on && $urandom_range(0, 59) == 0) wait_drained();
      end
    end

    wait_drained();
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/thbc_pkg.sv
sv/thbc_cfg.sv
sv/thbc_core.sv
sv/tap_hold_button_controller.sv
bench/tb_tap_hold_button_controller.sv
